// ===== src/u16u8_pkg.sv =====
`timescale 1ns / 1ps

package u16u8_pkg;

    // one utf-16 code unit on the input channel
    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_last_unit;
    } in_word_t;

    // one utf-8 byte on the output channel
    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
        logic       end_of_string;
    } out_word_t;

    // classified work for one input word: an optional U+FFFD, then an optional code point
    typedef struct packed {
        logic        has_repl;
        logic        has_main;
        logic [20:0] main_cp;
        logic        is_last;
    } run_t;

endpackage

// ===== src/u16u8_front.sv =====
`timescale 1ns / 1ps

module u16u8_front
    import u16u8_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     unit_valid,
    output logic     unit_ready,
    input  in_word_t unit_word,
    output logic     push_valid,
    input  logic     push_ready,
    output run_t     push_run
);

    localparam logic [5:0]  HIGH_TAG    = 6'b110110;
    localparam logic [5:0]  LOW_TAG     = 6'b110111;
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [10:0] PLANE_BASE  = 11'd64;

    logic       pending_reg;
    logic       pending_next;
    logic [9:0] held_reg;
    logic [9:0] held_next;
    logic       is_high;
    logic       is_low;
    logic       accept;

    assign is_high    = (unit_word.code_unit[15:10] == HIGH_TAG);
    assign is_low     = (unit_word.code_unit[15:10] == LOW_TAG);
    assign unit_ready = push_ready;
    assign accept     = unit_valid && unit_ready;

    // classify the incoming word against the held high surrogate
    always_comb
    begin
        push_run.has_repl = 1'b0;
        push_run.has_main = 1'b0;
        push_run.main_cp  = {5'd0, unit_word.code_unit};
        push_run.is_last  = unit_word.is_last_unit;
        pending_next      = 1'b0;
        held_next         = held_reg;
        if (pending_reg && is_low)
        begin
            // surrogate pair completes a supplementary code point
            push_run.has_main = 1'b1;
            push_run.main_cp  = {({1'b0, held_reg} + PLANE_BASE), unit_word.code_unit[9:0]};
        end
        else
        begin
            push_run.has_repl = pending_reg;
            if (is_high)
            begin
                if (unit_word.is_last_unit)
                begin
                    push_run.has_main = 1'b1;
                    push_run.main_cp  = REPLACEMENT;
                end
                else
                begin
                    pending_next = 1'b1;
                    held_next    = unit_word.code_unit[9:0];
                end
            end
            else if (is_low)
            begin
                push_run.has_main = 1'b1;
                push_run.main_cp  = REPLACEMENT;
            end
            else
            begin
                push_run.has_main = 1'b1;
            end
        end
    end

    // only words that yield bytes go into the queue
    assign push_valid = unit_valid && (push_run.has_repl || push_run.has_main);

    // held surrogate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/u16u8_queue.sv =====
`timescale 1ns / 1ps

module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  run_t push_run,
    output logic pop_valid,
    input  logic pop_ready,
    output run_t pop_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_run    = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

// ===== src/u16u8_back.sv =====
`timescale 1ns / 1ps

module u16u8_back
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  run_t      pop_run,
    output logic      byte_valid,
    input  logic      byte_ready,
    output out_word_t byte_word
);

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // number of utf-8 bytes for a code point
    function automatic logic [2:0] enc_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp[20:16] != '0)
            len = 3'd4;
        else if (cp[15:11] != '0)
            len = 3'd3;
        else if (cp[10:7] != '0)
            len = 3'd2;
        else
            len = 3'd1;
        return len;
    endfunction

    // one byte of the utf-8 encoding of a code point
    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                            input logic [1:0] pos);
        logic [7:0] b;
        b = {2'b10, cp[5:0]};
        case (len)
            3'd1:
            begin
                b = cp[7:0];
            end
            3'd2:
            begin
                if (pos == 2'd0)
                    b = {3'b110, cp[10:6]};
            end
            3'd3:
            begin
                if (pos == 2'd0)
                    b = {4'b1110, cp[15:12]};
                else if (pos == 2'd1)
                    b = {2'b10, cp[11:6]};
            end
            default:
            begin
                case (pos)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    logic       out_valid_reg;
    logic       out_valid_next;
    out_word_t  out_word_reg;
    out_word_t  out_word_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] main_len;
    logic [2:0] run_len;
    logic [2:0] repl_off;
    logic [2:0] main_pos;
    logic       in_repl;
    logic       last_byte;
    logic       load;
    logic [7:0] cur_byte;

    // position inside the current run
    assign main_len  = enc_len(pop_run.main_cp);
    assign repl_off  = pop_run.has_repl ? 3'd3 : 3'd0;
    assign run_len   = repl_off + (pop_run.has_main ? main_len : 3'd0);
    assign in_repl   = pop_run.has_repl && (idx_reg < 3'd3);
    assign main_pos  = idx_reg - repl_off;
    assign last_byte = (idx_reg == run_len - 3'd1);
    assign load      = pop_valid && (!out_valid_reg || byte_ready);
    assign pop_ready = load && last_byte;

    // byte select
    always_comb
    begin
        if (in_repl)
        begin
            case (idx_reg[1:0])
                2'd0:    cur_byte = REPL_B0;
                2'd1:    cur_byte = REPL_B1;
                default: cur_byte = REPL_B2;
            endcase
        end
        else
        begin
            cur_byte = enc_byte(pop_run.main_cp, main_len, main_pos[1:0]);
        end
    end

    // output register and run index
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        idx_next       = idx_reg;
        if (out_valid_reg && byte_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next              = 1'b1;
            out_word_next.utf8_byte     = cur_byte;
            out_word_next.last_of_run   = last_byte;
            out_word_next.end_of_string = last_byte && pop_run.is_last;
            idx_next                    = last_byte ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign byte_valid = out_valid_reg;
    assign byte_word  = out_word_reg;

endmodule

// ===== src/utf16_to_utf8_transcoder.sv =====
// the first byte of a word goes through the run queue and then the output register
// throughput: one utf-8 byte per cycle from the output register while byte_ready is high;
//   a word gives 0 to 6 bytes (1 to 3 for a basic plane character, 4 for a surrogate pair)
// the front takes a new word whenever the run queue has a free slot
// reset: rst_n asynchronous, active low; clears the held surrogate, the queue and the output
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      unit_valid,
    output logic      unit_ready,
    input  in_word_t  unit_word,
    output logic      byte_valid,
    input  logic      byte_ready,
    output out_word_t byte_word
);

    logic push_valid;
    logic push_ready;
    run_t push_run;
    logic pop_valid;
    logic pop_ready;
    run_t pop_run;

    // classification and surrogate pairing
    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_word  (unit_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run)
    );

    // run queue between front and back
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_run    (pop_run)
    );

    // byte serialiser
    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_run    (pop_run),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word)
    );

endmodule

// ===== src/u16u8_checker.sv =====
`timescale 1ns / 1ps

module u16u8_checker
    import u16u8_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      unit_valid,
    input logic      unit_ready,
    input in_word_t  unit_word,
    input logic      byte_valid,
    input logic      byte_ready,
    input out_word_t byte_word
);

    // a waiting input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_ready |=> unit_valid && $stable(unit_word))
        else $error("input word changed while waiting");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(byte_word))
        else $error("output word changed while stalled");

    // end of string only on the last byte of a run
    a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_word.end_of_string |-> byte_word.last_of_run)
        else $error("end of string outside last byte of run");

    // an ascii byte always closes its run
    a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_word.utf8_byte[7] |-> byte_word.last_of_run)
        else $error("ascii byte not last of run");

    // a lead byte is never the last of a run
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && (byte_word.utf8_byte[7:6] == 2'b11) |-> !byte_word.last_of_run)
        else $error("lead byte closes a run");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (.*);

// ===== bench/utf8_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package utf8_scoreboard_pkg;
    import u16u8_pkg::*;

    // utf-16 surrogate ranges and code point constants
    localparam bit [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam bit [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam bit [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam bit [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam bit [20:0] SUPP_PLANE_BASE = 21'h10000;
    localparam bit [20:0] REPLACEMENT_CP  = 21'h0FFFD;

    class utf8_byte_scoreboard;
        bit          surrogate_held;
        bit [9:0]    held_bits;
        out_word_t   expected_bytes[$];
        out_word_t   run_bytes[$];
        int unsigned units_noted;
        int unsigned pairs_formed;
        int unsigned replacements_made;
        int unsigned bytes_checked;

        function new();
            surrogate_held    = 1'b0;
            held_bits         = '0;
            units_noted       = 0;
            pairs_formed      = 0;
            replacements_made = 0;
            bytes_checked     = 0;
        endfunction

        function void append_byte(bit [7:0] value);
            out_word_t w;
            w.utf8_byte     = value;
            w.last_of_run   = 1'b0;
            w.end_of_string = 1'b0;
            run_bytes.push_back(w);
        endfunction

        // utf-8 bytes of one code point, shortest form
        function void encode_code_point(bit [20:0] cp);
            if (cp < 21'h80)
            begin
                append_byte(cp[7:0]);
            end
            else if (cp < 21'h800)
            begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            else if (cp < SUPP_PLANE_BASE)
            begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            else
            begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endfunction

        function void emit_replacement();
            encode_code_point(REPLACEMENT_CP);
            replacements_made++;
        endfunction

        // work out the bytes that one accepted word must produce
        function void note_unit(in_word_t w);
            bit [15:0] cu;
            bit        is_high;
            bit        is_low;
            bit        paired;
            out_word_t tail;
            cu      = w.code_unit;
            is_high = (cu >= HIGH_SURR_FIRST) && (cu <= HIGH_SURR_LAST);
            is_low  = (cu >= LOW_SURR_FIRST) && (cu <= LOW_SURR_LAST);
            paired  = 1'b0;
            units_noted++;
            run_bytes.delete();

            // resolve a held high surrogate first
            if (surrogate_held)
            begin
                surrogate_held = 1'b0;
                if (is_low)
                begin
                    encode_code_point(SUPP_PLANE_BASE + {held_bits, cu[9:0]});
                    pairs_formed++;
                    paired = 1'b1;
                end
                else
                begin
                    emit_replacement();
                end
                held_bits = '0;
            end

            // then the new word on its own
            if (!paired)
            begin
                if (is_high)
                begin
                    if (w.is_last_unit)
                    begin
                        emit_replacement();
                    end
                    else
                    begin
                        surrogate_held = 1'b1;
                        held_bits      = cu[9:0];
                    end
                end
                else if (is_low)
                begin
                    emit_replacement();
                end
                else
                begin
                    encode_code_point({5'b0, cu});
                end
            end

            // flag the final byte of the run
            if (run_bytes.size() > 0)
            begin
                tail               = run_bytes.pop_back();
                tail.last_of_run   = 1'b1;
                tail.end_of_string = w.is_last_unit;
                run_bytes.push_back(tail);
            end
            foreach (run_bytes[i])
                expected_bytes.push_back(run_bytes[i]);
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction

        // empty string when the byte matches the oldest expectation
        function string check_byte(out_word_t got);
            out_word_t want;
            string     why;
            if (expected_bytes.size() == 0)
                return $sformatf("byte %02h arrived with nothing expected", got.utf8_byte);
            want = expected_bytes.pop_front();
            bytes_checked++;
            why = "";
            if (got.utf8_byte !== want.utf8_byte)
                why = {why, $sformatf(" utf8_byte %02h/%02h", got.utf8_byte, want.utf8_byte)};
            if (got.last_of_run !== want.last_of_run)
                why = {why, $sformatf(" last_of_run %b/%b", got.last_of_run,
                                      want.last_of_run)};
            if (got.end_of_string !== want.end_of_string)
                why = {why, $sformatf(" end_of_string %b/%b", got.end_of_string,
                                      want.end_of_string)};
            if (why != "")
                why = {$sformatf("byte %0d got/wanted:", bytes_checked), why};
            return why;
        endfunction
    endclass

endpackage

// ===== bench/utf16_to_utf8_transcoder_tb.sv =====
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_tb;
    import u16u8_pkg::*;
    import utf8_scoreboard_pkg::*;

    localparam int DIRECTED_UNITS    = 24;
    localparam int RANDOM_UNITS      = 500;
    localparam int IDLE_CUTOFF       = 440;
    localparam int LONG_STALL_START  = 60;
    localparam int LONG_STALL_CYCLES = 80;
    localparam int DRAIN_LIMIT       = 5000;
    localparam int SETTLE_CYCLES     = 10;

    logic      clk;
    logic      rst_n;
    logic      unit_valid;
    logic      unit_ready;
    in_word_t  unit_word;
    logic      byte_valid;
    logic      byte_ready;
    out_word_t byte_word;

    utf8_byte_scoreboard sb;
    int    units_accepted  = 0;
    int    mismatch_count  = 0;
    bit    idle_enabled    = 1'b1;
    bit    long_stall_done = 1'b0;
    string mismatch_text;

    utf16_to_utf8_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_word  (unit_word),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string text);
        $display("mismatch at %0t: %s", $realtime, text);
        mismatch_count++;
    endtask

    function automatic in_word_t word_of(bit [15:0] cu, bit last);
        in_word_t w;
        w.code_unit    = cu;
        w.is_last_unit = last;
        return w;
    endfunction

    // a unit outside the surrogate ranges, spread over the 1, 2 and 3 byte forms
    function automatic bit [15:0] pick_plain_unit();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, HIGH_SURR_FIRST - 1));
            default: return 16'($urandom_range(LOW_SURR_LAST + 1, 16'hFFFF));
        endcase
    endfunction

    function automatic bit [15:0] pick_any_unit();
        case ($urandom_range(0, 5))
            0, 1:    return pick_plain_unit();
            2:       return 16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST));
            3:       return 16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST));
            default: return 16'($urandom());
        endcase
    endfunction

    // offer one word, with an optional idle burst ahead of it
    task automatic send_unit(input in_word_t w);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            unit_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        unit_valid <= 1'b1;
        unit_word  <= w;
        @(posedge clk);
        while (!unit_ready) @(posedge clk);
        sb.note_unit(w);
        units_accepted++;
    endtask

    // well-formed string: plain characters and proper surrogate pairs
    task automatic send_random_string();
        in_word_t run_units[$];
        in_word_t tail;
        int       char_count;
        char_count = $urandom_range(1, 8);
        for (int c = 0; c < char_count; c++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                run_units.push_back(word_of(16'($urandom_range(HIGH_SURR_FIRST,
                                                               HIGH_SURR_LAST)), 1'b0));
                run_units.push_back(word_of(16'($urandom_range(LOW_SURR_FIRST,
                                                               LOW_SURR_LAST)), 1'b0));
            end
            else
            begin
                run_units.push_back(word_of(pick_plain_unit(), 1'b0));
            end
        end
        tail              = run_units.pop_back();
        tail.is_last_unit = 1'b1;
        run_units.push_back(tail);
        foreach (run_units[i])
            send_unit(run_units[i]);
    endtask

    // broken sequences: any unit class, random end flags
    task automatic send_noise();
        int unit_count;
        unit_count = $urandom_range(1, 6);
        repeat (unit_count)
            send_unit(word_of(pick_any_unit(), $urandom_range(0, 3) == 0));
    endtask

    // output side: random stalls, plus one long hold to back up the input
    initial
    begin
        byte_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!long_stall_done && units_accepted >= LONG_STALL_START)
            begin
                byte_ready <= 1'b0;
                for (int c = 0; c < LONG_STALL_CYCLES; c++)
                    @(posedge clk);
                long_stall_done = 1'b1;
            end
            else if (idle_enabled && $urandom_range(0, 3) == 0)
            begin
                byte_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            byte_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // check every byte taken from the output
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
        begin
            mismatch_text = sb.check_byte(byte_word);
            if (mismatch_text != "")
                report_mismatch(mismatch_text);
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("[utf16_to_utf8_transcoder] ERROR");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        in_word_t directed[$];
        int       drain_cycles;
        sb = new();
        rst_n      <= 1'b0;
        unit_valid <= 1'b0;
        unit_word  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes and the boundaries of each utf-8 length
        directed.push_back(word_of(16'h0000, 1'b0));
        directed.push_back(word_of(16'h007F, 1'b0));
        directed.push_back(word_of(16'h0080, 1'b0));
        directed.push_back(word_of(16'h07FF, 1'b0));
        directed.push_back(word_of(16'h0800, 1'b0));
        directed.push_back(word_of(16'(HIGH_SURR_FIRST - 1), 1'b0));
        directed.push_back(word_of(16'(LOW_SURR_LAST + 1), 1'b0));
        directed.push_back(word_of(16'hFFFF, 1'b1));
        // lowest and highest supplementary code points
        directed.push_back(word_of(HIGH_SURR_FIRST, 1'b0));
        directed.push_back(word_of(LOW_SURR_FIRST, 1'b0));
        directed.push_back(word_of(HIGH_SURR_LAST, 1'b0));
        directed.push_back(word_of(LOW_SURR_LAST, 1'b1));
        // high surrogate ending the string
        directed.push_back(word_of(HIGH_SURR_LAST, 1'b1));
        // held high then a plain character
        directed.push_back(word_of(HIGH_SURR_FIRST, 1'b0));
        directed.push_back(word_of(16'h0041, 1'b0));
        // held high then another high, which then pairs
        directed.push_back(word_of(16'hDA00, 1'b0));
        directed.push_back(word_of(16'hDB00, 1'b0));
        directed.push_back(word_of(LOW_SURR_FIRST, 1'b0));
        // held high then a high on the last word: two replacements at once
        directed.push_back(word_of(16'hD900, 1'b0));
        directed.push_back(word_of(HIGH_SURR_LAST, 1'b1));
        // unpaired low surrogates
        directed.push_back(word_of(LOW_SURR_FIRST, 1'b0));
        directed.push_back(word_of(LOW_SURR_LAST, 1'b1));
        // a literal U+FFFD word, then a zero word at the end of a string
        directed.push_back(word_of(16'hFFFD, 1'b0));
        directed.push_back(word_of(16'h0000, 1'b1));
        foreach (directed[i])
            send_unit(directed[i]);

        // random strings, mostly well formed
        while (units_accepted < DIRECTED_UNITS + RANDOM_UNITS)
        begin
            idle_enabled = (units_accepted < IDLE_CUTOFF) &&
                           ((units_accepted / 64) % 3 != 2);
            if ($urandom_range(0, 4) != 0)
                send_random_string();
            else
                send_noise();
        end
        unit_valid <= 1'b0;

        // drain
        drain_cycles = 0;
        while (sb.outstanding() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived", sb.outstanding()));

        $display("run covered %0d words, %0d bytes, %0d surrogate pairs, %0d U+FFFD",
                 sb.units_noted, sb.bytes_checked, sb.pairs_formed, sb.replacements_made);
        $display("output held off for %0d cycles once; %0d mismatches",
                 LONG_STALL_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("[utf16_to_utf8_transcoder] OK");
        else
            $display("[utf16_to_utf8_transcoder] ERROR");
        $finish;
    end

endmodule
